// File: sv/vrpe_pkg.sv
// Shared types, codes and constants for the voice record and playback engine.
// No dependencies; the RTL uses scoped names, and the testbench imports it.
`timescale 1ns / 1ps
`default_nettype none

package vrpe_pkg;

   // Default sizes, handed to the top level parameters.
   localparam int MEM_DEPTH_DEF     = 65536;
   localparam int CHUNK_SAMPLES_DEF = 256;

   // Fixed field widths of the ports.
   localparam int SAMPLE_W = 16;
   localparam int COUNT_W  = 17;
   localparam int GAIN_W   = 4;
   localparam int LIMIT_W  = 17;
   localparam int OPCODE_W = 3;
   localparam int MODE_W   = 2;

   // Configuration register indexes and reset values.
   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN_SHIFT   = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RECORD_LIMIT = 1'b1;
   localparam logic [LIMIT_W-1:0]     RECORD_LIMIT_RST = 17'h10000;

   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

   typedef enum logic [OPCODE_W-1:0] {
      OP_MIC     = 3'd0,
      OP_SPEAKER = 3'd1,
      OP_SHORT   = 3'd2,
      OP_LONG    = 3'd3,
      OP_STOP    = 3'd4,
      OP_ENTER   = 3'd5,
      OP_EXIT    = 3'd6
   } opcode_type;

   typedef enum logic [MODE_W-1:0] {
      MODE_IDLE = 2'd0,
      MODE_REC  = 2'd1,
      MODE_PLAY = 2'd2
   } mode_type;

   // What the peak meter does for one transaction.
   typedef enum logic [2:0] {
      PK_NONE,
      PK_COUNT,
      PK_LATCH,
      PK_CLEAR_CHUNK,
      PK_CLEAR_ALL
   } peak_op_type;

   typedef struct packed {
      peak_op_type op;
      logic        at_end;    // last sample of the limit or of the buffer
      logic        from_ram;  // sample comes from the memory read port
   } peak_cmd_type;

   // Recorder state after a transaction, as reported on the result channel.
   typedef struct packed {
      mode_type             mode;
      logic                 enabled;
      logic [COUNT_W-1:0]   count;
   } ctrl_status_type;

endpackage : vrpe_pkg

`default_nettype wire

// File: sv/voice_record_playback_engine.sv
// A transaction passes through the first stage and then the output register.
// Throughput: one transaction per cycle unless the result side stalls; the
// memory read runs in the first stage and the peak meter in the second.
// Reset is synchronous and active high: idle, not entered, counts and peak
// cleared, gain shift 0, record limit 65536. The sample memory needs no clearing.
`timescale 1ns / 1ps
`default_nettype none

// Top level of the voice record and playback engine.
// Depends on vrpe_pkg, vrpe_ram, vrpe_ctrl and vrpe_peak.
module voice_record_playback_engine #(
   parameter int MEM_DEPTH     = vrpe_pkg::MEM_DEPTH_DEF,
   parameter int CHUNK_SAMPLES = vrpe_pkg::CHUNK_SAMPLES_DEF
) (
   input  wire logic                                     clock,
   input  wire logic                                     reset,
   // Configuration write port.
   input  wire logic                                     csr_we,
   input  wire logic [vrpe_pkg::CSR_INDEX_W-1:0]         csr_index,
   input  wire logic [vrpe_pkg::LIMIT_W-1:0]             csr_wdata,
   // Event channel.
   input  wire logic                                     req_valid,
   output logic                                          req_stall,
   input  wire logic [vrpe_pkg::OPCODE_W-1:0]            req_opcode,
   input  wire logic signed [vrpe_pkg::SAMPLE_W-1:0]     req_mic_sample,
   // Result channel.
   output logic                                          rsp_valid,
   input  wire logic                                     rsp_stall,
   output logic [vrpe_pkg::MODE_W-1:0]                   rsp_mode,
   output logic                                          rsp_enabled,
   output logic [vrpe_pkg::SAMPLE_W-1:0]                 rsp_peak_level,
   output logic [vrpe_pkg::COUNT_W-1:0]                  rsp_sample_count,
   output logic signed [vrpe_pkg::SAMPLE_W-1:0]          rsp_play_sample,
   output logic                                          rsp_play_valid,
   output logic                                          rsp_has_recording
);

   localparam int ADDR_W = $clog2(MEM_DEPTH);

   // Configuration registers. They are to be written only while the engine is idle; the block does not enforce it.
   logic [vrpe_pkg::GAIN_W-1:0]  gain_shift_ff;
   logic [vrpe_pkg::LIMIT_W-1:0] record_limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_shift_ff   <= '0;
         record_limit_ff <= vrpe_pkg::RECORD_LIMIT_RST;
      end else if (csr_we) begin
         case (csr_index)
            vrpe_pkg::CSR_GAIN_SHIFT:   gain_shift_ff   <= csr_wdata[vrpe_pkg::GAIN_W-1:0];
            vrpe_pkg::CSR_RECORD_LIMIT: record_limit_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Handshake. The first stage holds the transaction whose memory read is in
   // flight; the output register holds the finished result. The first stage
   // moves on whenever the output register is empty or being emptied, so a new
   // transaction is taken every cycle unless the result side stalls.
   logic accept;
   logic out_ready;
   logic s1_advance;
   logic s1_valid_ff;

   assign out_ready  = !rsp_valid || !rsp_stall;
   assign req_stall  = s1_valid_ff && !out_ready;
   assign accept     = req_valid && !req_stall;
   assign s1_advance = s1_valid_ff && out_ready;

   // Control: state updates at the accepting edge; the memory write and read
   // are issued in the same cycle.
   logic                                 wr_en;
   logic                                 rd_en;
   logic [ADDR_W-1:0]                    wr_addr;
   logic [ADDR_W-1:0]                    rd_addr;
   logic signed [vrpe_pkg::SAMPLE_W-1:0] gained;
   vrpe_pkg::peak_cmd_type               peak_cmd;
   vrpe_pkg::ctrl_status_type            status;

   vrpe_ctrl #(
      .MEM_DEPTH (MEM_DEPTH)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .opcode       (req_opcode),
      .mic_sample   (req_mic_sample),
      .gain_shift   (gain_shift_ff),
      .record_limit (record_limit_ff),
      .wr_en        (wr_en),
      .rd_en        (rd_en),
      .wr_addr      (wr_addr),
      .rd_addr      (rd_addr),
      .gained       (gained),
      .peak_cmd     (peak_cmd),
      .status       (status)
   );

   // Sample memory. Reads always fall below the write count, so every entry
   // read was written by an earlier transaction at an earlier edge. The read
   // data register only loads on a read, so it holds while the first stage waits.
   logic [vrpe_pkg::SAMPLE_W-1:0] ram_rd_data;

   vrpe_ram #(
      .WIDTH (vrpe_pkg::SAMPLE_W),
      .DEPTH (MEM_DEPTH)
   ) u_sample_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (gained),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (ram_rd_data)
   );

   // First stage registers.
   vrpe_pkg::peak_cmd_type               s1_cmd_ff;
   vrpe_pkg::ctrl_status_type            s1_status_ff;
   logic signed [vrpe_pkg::SAMPLE_W-1:0] s1_gained_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (out_ready) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_cmd_ff    <= peak_cmd;
         s1_status_ff <= status;
         s1_gained_ff <= gained;
      end
   end

   // Peak meter works on the played sample or on the gained recorded sample.
   logic signed [vrpe_pkg::SAMPLE_W-1:0] meter_sample;
   logic [vrpe_pkg::SAMPLE_W-1:0]        shown_in;

   assign meter_sample = s1_cmd_ff.from_ram ? $signed(ram_rd_data) : s1_gained_ff;

   vrpe_peak #(
      .CHUNK_SAMPLES (CHUNK_SAMPLES)
   ) u_peak (
      .clock    (clock),
      .reset    (reset),
      .advance  (s1_advance),
      .cmd      (s1_cmd_ff),
      .sample   (meter_sample),
      .shown_in (shown_in)
   );

   // Output register.
   logic                                 rsp_valid_ff;
   vrpe_pkg::mode_type                   rsp_mode_ff;
   logic                                 rsp_enabled_ff;
   logic [vrpe_pkg::SAMPLE_W-1:0]        rsp_peak_level_ff;
   logic [vrpe_pkg::COUNT_W-1:0]         rsp_sample_count_ff;
   logic signed [vrpe_pkg::SAMPLE_W-1:0] rsp_play_sample_ff;
   logic                                 rsp_play_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance) begin
         rsp_mode_ff         <= s1_status_ff.mode;
         rsp_enabled_ff      <= s1_status_ff.enabled;
         rsp_sample_count_ff <= s1_status_ff.count;
         rsp_peak_level_ff   <= shown_in;
         rsp_play_valid_ff   <= s1_cmd_ff.from_ram;
         rsp_play_sample_ff  <= s1_cmd_ff.from_ram ? $signed(ram_rd_data) : '0;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_mode          = rsp_mode_ff;
   assign rsp_enabled       = rsp_enabled_ff;
   assign rsp_peak_level    = rsp_peak_level_ff;
   assign rsp_sample_count  = rsp_sample_count_ff;
   assign rsp_play_sample   = rsp_play_sample_ff;
   assign rsp_play_valid    = rsp_play_valid_ff;
   assign rsp_has_recording = rsp_sample_count_ff != '0;

endmodule : voice_record_playback_engine

`default_nettype wire

// File: sv/vrpe_ram.sv
// Generic single write port, single read port RAM with a registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module vrpe_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 65536
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule : vrpe_ram

`default_nettype wire

// File: sv/vrpe_ctrl.sv
// Recorder control: mode, enable, write count and read offset, event decode,
// gain and saturation of microphone samples. Depends on vrpe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vrpe_ctrl #(
   parameter int MEM_DEPTH = vrpe_pkg::MEM_DEPTH_DEF
) (
   input  wire logic                                     clock,
   input  wire logic                                     reset,
   input  wire logic                                     accept,
   input  wire logic [vrpe_pkg::OPCODE_W-1:0]            opcode,
   input  wire logic signed [vrpe_pkg::SAMPLE_W-1:0]     mic_sample,
   input  wire logic [vrpe_pkg::GAIN_W-1:0]              gain_shift,
   input  wire logic [vrpe_pkg::LIMIT_W-1:0]             record_limit,
   output logic                                          wr_en,
   output logic                                          rd_en,
   output logic [$clog2(MEM_DEPTH)-1:0]                  wr_addr,
   output logic [$clog2(MEM_DEPTH)-1:0]                  rd_addr,
   output logic signed [vrpe_pkg::SAMPLE_W-1:0]          gained,
   output vrpe_pkg::peak_cmd_type                        peak_cmd,
   output vrpe_pkg::ctrl_status_type                     status
);

   localparam int ADDR_W = $clog2(MEM_DEPTH);
   localparam int CNT_W  = $clog2(MEM_DEPTH + 1);
   localparam int LIM_W  = (CNT_W > vrpe_pkg::LIMIT_W) ? CNT_W : vrpe_pkg::LIMIT_W;

   vrpe_pkg::mode_type  mode_ff, mode_in;
   logic                active_ff, active_in;
   logic [CNT_W-1:0]    wcount_ff, wcount_in;
   logic [CNT_W-1:0]    roffset_ff, roffset_in;

   logic [LIM_W-1:0]    limit_eff;
   logic [CNT_W-1:0]    wcount_inc;
   logic [CNT_W-1:0]    roffset_inc;
   logic                room_left;
   logic                now_full;
   logic                data_left;
   logic                last_read;
   vrpe_pkg::mode_type     pb_mode;
   vrpe_pkg::peak_op_type  pb_op;
   logic [31:0]         gain_wide;

   // Gain and 16-bit saturation of the microphone sample.
   always_comb begin
      gain_wide = {{(32 - vrpe_pkg::SAMPLE_W){mic_sample[vrpe_pkg::SAMPLE_W-1]}}, mic_sample}
                  << gain_shift;
      if ($signed(gain_wide) > 32'sd32767) begin
         gained = vrpe_pkg::SAMPLE_MAX;
      end else if ($signed(gain_wide) < -32'sd32768) begin
         gained = vrpe_pkg::SAMPLE_MIN;
      end else begin
         gained = gain_wide[vrpe_pkg::SAMPLE_W-1:0];
      end
   end

   // A limit beyond the memory acts as the memory size.
   assign limit_eff   = (LIM_W'(record_limit) > LIM_W'(MEM_DEPTH)) ?
                        LIM_W'(MEM_DEPTH) : LIM_W'(record_limit);
   assign wcount_inc  = wcount_ff + CNT_W'(1);
   assign roffset_inc = roffset_ff + CNT_W'(1);
   assign room_left   = LIM_W'(wcount_ff) < limit_eff;
   assign now_full    = LIM_W'(wcount_inc) >= limit_eff;
   assign data_left   = roffset_ff < wcount_ff;
   assign last_read   = roffset_inc >= wcount_ff;

   // Starting playback with nothing recorded falls back to idle.
   assign pb_mode = (wcount_ff == '0) ? vrpe_pkg::MODE_IDLE : vrpe_pkg::MODE_PLAY;
   assign pb_op   = (wcount_ff == '0) ? vrpe_pkg::PK_CLEAR_ALL : vrpe_pkg::PK_CLEAR_CHUNK;

   always_comb begin
      mode_in           = mode_ff;
      active_in         = active_ff;
      wcount_in         = wcount_ff;
      roffset_in        = roffset_ff;
      wr_en             = 1'b0;
      rd_en             = 1'b0;
      peak_cmd.op       = vrpe_pkg::PK_NONE;
      peak_cmd.at_end   = 1'b0;
      peak_cmd.from_ram = 1'b0;
      if (accept) begin
         case (opcode)
            vrpe_pkg::OP_MIC: begin
               if (active_ff && mode_ff == vrpe_pkg::MODE_REC) begin
                  if (room_left) begin
                     wr_en           = 1'b1;
                     wcount_in       = wcount_inc;
                     peak_cmd.op     = vrpe_pkg::PK_COUNT;
                     peak_cmd.at_end = now_full;
                     if (now_full) begin
                        roffset_in = '0;
                        mode_in    = vrpe_pkg::MODE_IDLE;
                     end
                  end else begin
                     peak_cmd.op = vrpe_pkg::PK_LATCH;
                     roffset_in  = '0;
                     mode_in     = vrpe_pkg::MODE_IDLE;
                  end
               end
            end
            vrpe_pkg::OP_SPEAKER: begin
               if (active_ff && mode_ff == vrpe_pkg::MODE_PLAY) begin
                  if (data_left) begin
                     rd_en             = 1'b1;
                     roffset_in        = roffset_inc;
                     peak_cmd.op       = vrpe_pkg::PK_COUNT;
                     peak_cmd.at_end   = last_read;
                     peak_cmd.from_ram = 1'b1;
                  end else begin
                     roffset_in  = '0;
                     peak_cmd.op = vrpe_pkg::PK_CLEAR_ALL;
                     mode_in     = vrpe_pkg::MODE_IDLE;
                  end
               end
            end
            vrpe_pkg::OP_SHORT: begin
               if (active_ff) begin
                  if (mode_ff == vrpe_pkg::MODE_REC) begin
                     roffset_in  = '0;
                     peak_cmd.op = pb_op;
                     mode_in     = pb_mode;
                  end else begin
                     wcount_in   = '0;
                     roffset_in  = '0;
                     peak_cmd.op = vrpe_pkg::PK_CLEAR_ALL;
                     mode_in     = vrpe_pkg::MODE_REC;
                  end
               end
            end
            vrpe_pkg::OP_LONG: begin
               if (active_ff && mode_ff != vrpe_pkg::MODE_REC) begin
                  roffset_in  = '0;
                  peak_cmd.op = pb_op;
                  mode_in     = pb_mode;
               end
            end
            vrpe_pkg::OP_STOP: begin
               wcount_in   = '0;
               roffset_in  = '0;
               peak_cmd.op = vrpe_pkg::PK_CLEAR_ALL;
               if (active_ff) begin
                  mode_in = vrpe_pkg::MODE_IDLE;
               end
            end
            vrpe_pkg::OP_ENTER: begin
               wcount_in   = '0;
               roffset_in  = '0;
               peak_cmd.op = vrpe_pkg::PK_CLEAR_ALL;
               mode_in     = vrpe_pkg::MODE_IDLE;
               active_in   = 1'b1;
            end
            vrpe_pkg::OP_EXIT: begin
               wcount_in   = '0;
               roffset_in  = '0;
               peak_cmd.op = vrpe_pkg::PK_CLEAR_ALL;
               mode_in     = vrpe_pkg::MODE_IDLE;
               active_in   = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= vrpe_pkg::MODE_IDLE;
         active_ff  <= 1'b0;
         wcount_ff  <= '0;
         roffset_ff <= '0;
      end else begin
         mode_ff    <= mode_in;
         active_ff  <= active_in;
         wcount_ff  <= wcount_in;
         roffset_ff <= roffset_in;
      end
   end

   assign wr_addr = wcount_ff[ADDR_W-1:0];
   assign rd_addr = roffset_ff[ADDR_W-1:0];

   assign status.mode    = mode_in;
   assign status.enabled = active_in;
   assign status.count   = LIM_W'(wcount_in) >> 0 == '0 ? '0 :
                           vrpe_pkg::COUNT_W'(LIM_W'(wcount_in));

endmodule : vrpe_ctrl

`default_nettype wire

// File: sv/vrpe_peak.sv
// Chunk-wise absolute peak meter with a latched display value.
// Depends on vrpe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vrpe_peak #(
   parameter int CHUNK_SAMPLES = vrpe_pkg::CHUNK_SAMPLES_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 advance,
   input  wire vrpe_pkg::peak_cmd_type               cmd,
   input  wire logic signed [vrpe_pkg::SAMPLE_W-1:0] sample,
   output logic [vrpe_pkg::SAMPLE_W-1:0]             shown_in
);

   localparam int CP_W = $clog2(CHUNK_SAMPLES + 1);

   logic [vrpe_pkg::SAMPLE_W-1:0] running_ff, running_in;
   logic [vrpe_pkg::SAMPLE_W-1:0] shown_ff;
   logic [CP_W-1:0]               chunk_pos_ff, chunk_pos_in;
   logic [vrpe_pkg::SAMPLE_W:0]   abs_wide;
   logic [vrpe_pkg::SAMPLE_W-1:0] level;
   logic [vrpe_pkg::SAMPLE_W-1:0] new_max;
   logic                          chunk_done;

   // The most negative sample gives 32768, which still fits in 16 bits.
   assign abs_wide   = sample[vrpe_pkg::SAMPLE_W-1] ?
                       -{sample[vrpe_pkg::SAMPLE_W-1], sample} :
                       {sample[vrpe_pkg::SAMPLE_W-1], sample};
   assign level      = abs_wide[vrpe_pkg::SAMPLE_W-1:0];
   assign new_max    = (level > running_ff) ? level : running_ff;
   assign chunk_done = (chunk_pos_ff == CP_W'(CHUNK_SAMPLES - 1)) || cmd.at_end;

   always_comb begin
      running_in   = running_ff;
      shown_in     = shown_ff;
      chunk_pos_in = chunk_pos_ff;
      case (cmd.op)
         vrpe_pkg::PK_COUNT: begin
            if (chunk_done) begin
               shown_in     = new_max;
               running_in   = '0;
               chunk_pos_in = '0;
            end else begin
               running_in   = new_max;
               chunk_pos_in = chunk_pos_ff + CP_W'(1);
            end
         end
         vrpe_pkg::PK_LATCH: begin
            shown_in     = running_ff;
            running_in   = '0;
            chunk_pos_in = '0;
         end
         vrpe_pkg::PK_CLEAR_CHUNK: begin
            running_in   = '0;
            chunk_pos_in = '0;
         end
         vrpe_pkg::PK_CLEAR_ALL: begin
            shown_in     = '0;
            running_in   = '0;
            chunk_pos_in = '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff   <= '0;
         shown_ff     <= '0;
         chunk_pos_ff <= '0;
      end else if (advance) begin
         running_ff   <= running_in;
         shown_ff     <= shown_in;
         chunk_pos_ff <= chunk_pos_in;
      end
   end

endmodule : vrpe_peak

`default_nettype wire

// File: sv/vrpe_checker.sv
// Port-level checks for the voice record and playback engine, bound to the top.
// Depends on vrpe_pkg and voice_record_playback_engine.
`timescale 1ns / 1ps
`default_nettype none

module vrpe_checker (
   input wire logic                                 clock,
   input wire logic                                 reset,
   input wire logic                                 req_valid,
   input wire logic                                 req_stall,
   input wire logic                                 rsp_valid,
   input wire logic                                 rsp_stall,
   input wire logic [vrpe_pkg::MODE_W-1:0]          rsp_mode,
   input wire logic                                 rsp_enabled,
   input wire logic [vrpe_pkg::COUNT_W-1:0]         rsp_sample_count,
   input wire logic signed [vrpe_pkg::SAMPLE_W-1:0] rsp_play_sample,
   input wire logic                                 rsp_play_valid,
   input wire logic                                 rsp_has_recording
);

   // A result held under stall keeps its played sample.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_play_sample))
      else $error("result changed while stalled");

   // Only a played sample may be nonzero.
   a_play_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_play_valid |-> rsp_play_sample == '0)
      else $error("play sample nonzero without play valid");

   // The recording flag follows the sample count.
   a_has_rec: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_has_recording == (rsp_sample_count != '0))
      else $error("has_recording disagrees with sample_count");

   // Outside the entered mode the recorder is idle and plays nothing.
   a_disabled_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_enabled |->
         rsp_mode == vrpe_pkg::MODE_IDLE && !rsp_play_valid)
      else $error("activity reported while not enabled");

   // The event side is only held back while a result is waiting.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without a stalled result");

endmodule : vrpe_checker

bind voice_record_playback_engine vrpe_checker u_vrpe_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_mode          (rsp_mode),
   .rsp_enabled       (rsp_enabled),
   .rsp_sample_count  (rsp_sample_count),
   .rsp_play_sample   (rsp_play_sample),
   .rsp_play_valid    (rsp_play_valid),
   .rsp_has_recording (rsp_has_recording)
);

`default_nettype wire

// File: tb/voice_record_playback_engine_tb.sv
// Self-checking testbench for the voice record and playback engine: directed
// and random event streams, checked in order against a transaction-level model.
// Depends on vrpe_pkg and the voice_record_playback_engine RTL.
`timescale 1ns / 1ps

module voice_record_playback_engine_tb;
   import vrpe_pkg::*;

   localparam int MEM_DEPTH     = MEM_DEPTH_DEF;
   localparam int CHUNK_SAMPLES = CHUNK_SAMPLES_DEF;
   // Cycles waited after the last report comes back, as a safe margin.
   localparam int SETTLE_CYCLES = 6;
   // No new random session starts once this many events have gone out.
   localparam int EVENT_TARGET  = 1550;
   // Opcode 7 is unassigned; the engine must treat it as a no-op.
   localparam logic [OPCODE_W-1:0] OP_UNUSED = 3'd7;
   // Mismatches beyond this many are still counted but no longer printed.
   localparam int MAX_PRINTED   = 100;

   // What the engine reports after one transaction.
   typedef struct {
      mode_type                   mode;
      logic                       enabled;
      logic [SAMPLE_W-1:0]        peak_level;
      logic [COUNT_W-1:0]         sample_count;
      logic signed [SAMPLE_W-1:0] play_sample;
      logic                       play_valid;
      logic                       has_recording;
   } engine_report_t;

   // Every input of the engine starts at a known value.
   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0]     csr_index = CSR_GAIN_SHIFT;
   logic [LIMIT_W-1:0]         csr_wdata = '0;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic [OPCODE_W-1:0]        req_opcode = OP_MIC;
   logic signed [SAMPLE_W-1:0] req_mic_sample = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic [MODE_W-1:0]          rsp_mode;
   logic                       rsp_enabled;
   logic [SAMPLE_W-1:0]        rsp_peak_level;
   logic [COUNT_W-1:0]         rsp_sample_count;
   logic signed [SAMPLE_W-1:0] rsp_play_sample;
   logic                       rsp_play_valid;
   logic                       rsp_has_recording;

   // Reports predicted for accepted events, oldest first.
   engine_report_t expected_reports[$];
   int             mismatch_count = 0;
   int             events_sent = 0;
   int             stall_left = 0;
   // Idling switches; each test phase turns them on or off.
   bit             req_gaps_on = 1'b0;
   bit             rsp_stalls_on = 1'b0;
   // Set while req_valid is still high from the last accepted transaction.
   bit             request_held = 1'b0;

   // Model state: the recording memory, the control state and the peak meter.
   logic [SAMPLE_W-1:0] recorded_samples [MEM_DEPTH];
   mode_type            engine_mode;
   logic                engine_active;
   int                  recorded_count;
   int                  play_offset;
   int                  chunk_peak;
   int                  shown_peak;
   int                  chunk_fill;
   logic [GAIN_W-1:0]   gain_shift_reg;
   logic [LIMIT_W-1:0]  record_limit_reg;

   voice_record_playback_engine #(
      .MEM_DEPTH    (MEM_DEPTH),
      .CHUNK_SAMPLES(CHUNK_SAMPLES)
   ) u_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_opcode       (req_opcode),
      .req_mic_sample   (req_mic_sample),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_mode         (rsp_mode),
      .rsp_enabled      (rsp_enabled),
      .rsp_peak_level   (rsp_peak_level),
      .rsp_sample_count (rsp_sample_count),
      .rsp_play_sample  (rsp_play_sample),
      .rsp_play_valid   (rsp_play_valid),
      .rsp_has_recording(rsp_has_recording)
   );

   always #1 clock = ~clock;

   // ------------------------------------------------------------------
   // Peak meter and recorder model.
   // ------------------------------------------------------------------

   function automatic void meter_clear();
      chunk_peak = 0;
      chunk_fill = 0;
   endfunction

   // The shown peak only moves when a chunk closes or the data runs out.
   function automatic void meter_latch();
      shown_peak = chunk_peak;
      meter_clear();
   endfunction

   function automatic void meter_sample(input int value, input bit at_end);
      int level;
      // The most negative sample reads as 32768, which still fits 16 bits.
      level = (value < 0) ? -value : value;
      if (level > chunk_peak) begin
         chunk_peak = level;
      end
      chunk_fill++;
      if (chunk_fill >= CHUNK_SAMPLES || at_end) begin
         meter_latch();
      end
   endfunction

   function automatic void clear_recording_counters();
      recorded_count = 0;
      play_offset = 0;
      shown_peak = 0;
      meter_clear();
   endfunction

   // Playback of an empty recording falls straight back to idle.
   function automatic void rewind_for_playback();
      play_offset = 0;
      meter_clear();
      if (recorded_count == 0) begin
         engine_mode = MODE_IDLE;
         shown_peak = 0;
      end else begin
         engine_mode = MODE_PLAY;
      end
   endfunction

   // Applies one event to the model and returns the report the engine owes.
   task automatic predict_engine_report(input logic [OPCODE_W-1:0] opcode,
                                        input logic signed [SAMPLE_W-1:0] mic,
                                        output engine_report_t report);
      int   limit;
      int   gained;
      int   played;
      logic played_valid;
      bit   full;
      played = 0;
      played_valid = 1'b0;
      // Limits beyond the memory depth act as the full depth.
      limit = (record_limit_reg > MEM_DEPTH) ? MEM_DEPTH : int'(record_limit_reg);
      case (opcode)
         OP_MIC: begin
            if (engine_active && engine_mode == MODE_REC) begin
               if (recorded_count < limit) begin
                  gained = int'(mic) * (1 << gain_shift_reg);
                  if (gained > int'(SAMPLE_MAX)) begin
                     gained = int'(SAMPLE_MAX);
                  end
                  if (gained < int'(SAMPLE_MIN)) begin
                     gained = int'(SAMPLE_MIN);
                  end
                  recorded_samples[recorded_count] = gained[SAMPLE_W-1:0];
                  recorded_count++;
                  full = (recorded_count >= limit);
                  meter_sample(gained, full);
                  if (full) begin
                     play_offset = 0;
                     engine_mode = MODE_IDLE;
                  end
               end else begin
                  // No room left: drop the sample and stop recording.
                  meter_latch();
                  play_offset = 0;
                  engine_mode = MODE_IDLE;
               end
            end
         end
         OP_SPEAKER: begin
            if (engine_active && engine_mode == MODE_PLAY) begin
               if (play_offset < recorded_count) begin
                  played = int'($signed(recorded_samples[play_offset]));
                  played_valid = 1'b1;
                  play_offset++;
                  meter_sample(played, play_offset >= recorded_count);
               end else begin
                  // Request past the last sample ends playback.
                  play_offset = 0;
                  shown_peak = 0;
                  meter_clear();
                  engine_mode = MODE_IDLE;
               end
            end
         end
         OP_SHORT: begin
            if (engine_active) begin
               if (engine_mode == MODE_REC) begin
                  rewind_for_playback();
               end else begin
                  clear_recording_counters();
                  engine_mode = MODE_REC;
               end
            end
         end
         OP_LONG: begin
            if (engine_active && engine_mode != MODE_REC) begin
               rewind_for_playback();
            end
         end
         OP_STOP: begin
            // Counters clear even when the recorder mode is not entered.
            clear_recording_counters();
            if (engine_active) begin
               engine_mode = MODE_IDLE;
            end
         end
         OP_ENTER: begin
            clear_recording_counters();
            engine_mode = MODE_IDLE;
            engine_active = 1'b1;
         end
         OP_EXIT: begin
            engine_active = 1'b0;
            clear_recording_counters();
            engine_mode = MODE_IDLE;
         end
         default: begin
         end
      endcase
      report.mode = engine_mode;
      report.enabled = engine_active;
      report.peak_level = shown_peak[SAMPLE_W-1:0];
      report.sample_count = recorded_count[COUNT_W-1:0];
      report.play_sample = played[SAMPLE_W-1:0];
      report.play_valid = played_valid;
      report.has_recording = (recorded_count != 0);
   endtask

   // ------------------------------------------------------------------
   // Event channel, configuration port and result checking.
   // ------------------------------------------------------------------

   task automatic report_mismatch(input string what, input logic signed [31:0] got,
                                  input logic signed [31:0] want);
      mismatch_count++;
      if (mismatch_count <= MAX_PRINTED) begin
         $display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
      end
   endtask

   // Lowers req_valid in the step of the last acceptance, if it is still up.
   task automatic drop_request();
      if (request_held) begin
         req_valid <= 1'b0;
         request_held = 1'b0;
      end
   endtask

   // Sends one event, after a random gap when gaps are on, and records the
   // report it must produce. The payload holds still while the engine stalls.
   task automatic send_event(input logic [OPCODE_W-1:0] opcode,
                             input logic signed [SAMPLE_W-1:0] mic);
      engine_report_t report;
      int             gap;
      gap = req_gaps_on ? $urandom_range(0, 15) : 0;
      if (gap > 0) begin
         drop_request();
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= opcode;
      req_mic_sample <= mic;
      predict_engine_report(opcode, mic, report);
      expected_reports.push_back(report);
      do @(posedge clock); while (req_stall);
      request_held = 1'b1;
      events_sent++;
   endtask

   // Waits until every report has come back and the pipeline is empty.
   task automatic wait_for_drain();
      drop_request();
      @(posedge clock);
      while (expected_reports.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] index,
                            input logic [LIMIT_W-1:0] value);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      if (index == CSR_GAIN_SHIFT) begin
         gain_shift_reg = value[GAIN_W-1:0];
      end else begin
         record_limit_reg = value;
      end
   endtask

   // Registers change only with the engine quiet. The gain write carries
   // random upper bits, which the engine must ignore.
   task automatic configure_engine(input logic [GAIN_W-1:0] gain,
                                   input logic [LIMIT_W-1:0] limit);
      wait_for_drain();
      write_csr(CSR_GAIN_SHIFT, {13'($urandom), gain});
      write_csr(CSR_RECORD_LIMIT, limit);
   endtask

   // Each accepted result is compared with the oldest prediction. The stall
   // is drawn anew after every accepted result and counts down every cycle.
   always @(posedge clock) begin : check_reports
      engine_report_t want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_reports.size() == 0) begin
            report_mismatch("result with nothing expected", rsp_mode, 0);
         end else begin
            want = expected_reports.pop_front();
            if (rsp_mode !== want.mode)
               report_mismatch("mode", rsp_mode, want.mode);
            if (rsp_enabled !== want.enabled)
               report_mismatch("enabled", rsp_enabled, want.enabled);
            if (rsp_peak_level !== want.peak_level)
               report_mismatch("peak_level", rsp_peak_level, want.peak_level);
            if (rsp_sample_count !== want.sample_count)
               report_mismatch("sample_count", rsp_sample_count, want.sample_count);
            if (rsp_play_sample !== want.play_sample)
               report_mismatch("play_sample", rsp_play_sample, want.play_sample);
            if (rsp_play_valid !== want.play_valid)
               report_mismatch("play_valid", rsp_play_valid, want.play_valid);
            if (rsp_has_recording !== want.has_recording)
               report_mismatch("has_recording", rsp_has_recording, want.has_recording);
         end
         stall_left = rsp_stalls_on ? $urandom_range(0, 15) : 0;
      end
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // ------------------------------------------------------------------
   // Stimulus helpers.
   // ------------------------------------------------------------------

   // Mostly full-range samples, with rails and small values mixed in so
   // that gained samples do not always saturate.
   function automatic logic signed [SAMPLE_W-1:0] random_mic();
      case ($urandom_range(0, 7))
         0: return SAMPLE_MAX;
         1: return SAMPLE_MIN;
         2, 3: return 16'($urandom_range(0, 511)) - 16'd256;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [GAIN_W-1:0] random_gain();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         default: return 4'($urandom_range(0, 15));
      endcase
   endfunction

   // Short limits dominate so that sessions stay brief; a few are long
   // enough to close a chunk, and the out-of-range values show up too.
   function automatic logic [LIMIT_W-1:0] random_limit();
      case ($urandom_range(0, 19))
         0: return '0;
         1: return RECORD_LIMIT_RST;
         2: return '1;
         3, 4, 5: return 17'($urandom_range(41, 300));
         default: return 17'($urandom_range(1, 40));
      endcase
   endfunction

   // Brings the engine into recording from whatever state the model is in.
   task automatic start_recording();
      if (!engine_active) begin
         send_event(OP_ENTER, random_mic());
      end
      if (engine_mode != MODE_REC) begin
         send_event(OP_SHORT, random_mic());
      end
   endtask

   // A short press ends a recording; otherwise a long press starts playback.
   task automatic enter_playback();
      if (engine_mode == MODE_REC) begin
         send_event(OP_SHORT, random_mic());
      end else begin
         send_event(OP_LONG, random_mic());
      end
   endtask

   // Now and then a random event, opcode 7 included, is slipped in first.
   task automatic send_with_noise(input logic [OPCODE_W-1:0] opcode);
      if ($urandom_range(0, 11) == 0) begin
         send_event(3'($urandom_range(0, 7)), random_mic());
      end
      send_event(opcode, random_mic());
   endtask

   // ------------------------------------------------------------------
   // Tests.
   // ------------------------------------------------------------------

   // A short walk through every event and the main special cases.
   task automatic test_directed_flow();
      // Recorder mode not entered: only stop, enter and exit take effect.
      send_event(OP_MIC, SAMPLE_MAX);
      send_event(OP_SPEAKER, '0);
      send_event(OP_SHORT, '0);
      send_event(OP_LONG, '0);
      send_event(OP_STOP, '0);
      send_event(OP_UNUSED, SAMPLE_MIN);
      send_event(OP_ENTER, '0);
      // Speaker request while idle, playback with nothing recorded, and a
      // mic sample outside recording are all ignored.
      send_event(OP_SPEAKER, '0);
      send_event(OP_LONG, '0);
      send_event(OP_MIC, 16'sd5);
      send_event(OP_SHORT, '0);
      send_event(OP_MIC, SAMPLE_MAX);
      send_event(OP_MIC, SAMPLE_MIN);
      send_event(OP_MIC, '0);
      send_event(OP_MIC, -16'sd1);
      send_event(OP_UNUSED, '0);
      send_event(OP_SHORT, '0);
      // Four samples come back, then the fifth request ends playback.
      repeat (5) send_event(OP_SPEAKER, '0);
      send_event(OP_LONG, '0);
      send_event(OP_SPEAKER, '0);
      // A short press while playing starts a fresh recording.
      send_event(OP_SHORT, '0);
      send_event(OP_STOP, '0);
      send_event(OP_EXIT, '0);
   endtask

   // Largest and a middle gain, with samples on both sides of saturation.
   task automatic test_gain_saturation();
      configure_engine(4'd15, RECORD_LIMIT_RST);
      start_recording();
      send_event(OP_MIC, 16'sd1);
      send_event(OP_MIC, -16'sd1);
      send_event(OP_MIC, '0);
      send_event(OP_MIC, SAMPLE_MIN);
      enter_playback();
      repeat (5) send_event(OP_SPEAKER, '0);
      configure_engine(4'd4, RECORD_LIMIT_RST);
      start_recording();
      send_event(OP_MIC, 16'sd2047);
      send_event(OP_MIC, 16'sd2048);
      send_event(OP_MIC, -16'sd2048);
      send_event(OP_MIC, -16'sd2049);
      enter_playback();
      repeat (5) send_event(OP_SPEAKER, '0);
   endtask

   task automatic test_record_limits();
      // A limit of one: the first sample fills the memory and latches the peak.
      configure_engine('0, 17'd1);
      start_recording();
      send_event(OP_MIC, SAMPLE_MIN);
      send_event(OP_MIC, SAMPLE_MAX);
      enter_playback();
      repeat (2) send_event(OP_SPEAKER, '0);
      // A limit of zero leaves no room, so the first sample ends recording.
      configure_engine('0, '0);
      start_recording();
      send_event(OP_MIC, 16'sd100);
      // The limit drops below the count while recording: the memory is full.
      configure_engine(4'd1, 17'd10);
      start_recording();
      repeat (3) send_event(OP_MIC, random_mic());
      configure_engine(4'd1, 17'd2);
      send_event(OP_MIC, random_mic());
      enter_playback();
      repeat (4) send_event(OP_SPEAKER, '0);
      // All ones lies beyond the memory depth and acts as the full depth.
      configure_engine(4'd2, '1);
      start_recording();
      repeat (3) send_event(OP_MIC, random_mic());
      enter_playback();
      repeat (4) send_event(OP_SPEAKER, '0);
   endtask

   // A recording longer than one chunk: the peak latches at the chunk end
   // and again at the last sample, both while recording and while playing.
   task automatic test_chunk_peak();
      configure_engine(random_gain(), 17'd300);
      start_recording();
      repeat (300) send_event(OP_MIC, random_mic());
      enter_playback();
      repeat (301) send_event(OP_SPEAKER, random_mic());
   endtask

   // Sessions of enter, record, play with random lengths and settings, with
   // stray events mixed in to break some of them.
   task automatic test_random_sessions();
      int limit;
      int cap;
      int takes;
      int replays;
      while (events_sent < EVENT_TARGET) begin
         req_gaps_on = ($urandom_range(0, 3) != 0);
         rsp_stalls_on = ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 2) == 0) begin
            configure_engine(random_gain(), random_limit());
         end else if ($urandom_range(0, 9) == 0) begin
            // Hold off until every outstanding report has come back.
            wait_for_drain();
         end
         if ($urandom_range(0, 5) == 0) begin
            send_event(OP_EXIT, random_mic());
         end
         start_recording();
         limit = (record_limit_reg > MEM_DEPTH) ? MEM_DEPTH : int'(record_limit_reg);
         cap = (limit > 300) ? 40 : limit;
         // For short limits, up to two samples past the limit exercise the full memory.
         takes = $urandom_range(0, cap + 2);
         repeat (takes) send_with_noise(OP_MIC);
         if ($urandom_range(0, 3) == 0) begin
            send_with_noise(OP_STOP);
         end
         enter_playback();
         replays = $urandom_range(0, recorded_count + 2);
         repeat (replays) send_with_noise(OP_SPEAKER);
      end
   endtask

   // ------------------------------------------------------------------
   // Test sequence.
   // ------------------------------------------------------------------

   initial begin
      // Model state after reset.
      engine_mode = MODE_IDLE;
      engine_active = 1'b0;
      clear_recording_counters();
      gain_shift_reg = '0;
      record_limit_reg = RECORD_LIMIT_RST;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // The directed walk runs back to back on both sides.
      test_directed_flow();
      req_gaps_on = 1'b1;
      rsp_stalls_on = 1'b1;
      test_gain_saturation();
      test_record_limits();
      test_chunk_peak();
      test_random_sessions();
      wait_for_drain();

      if (mismatch_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // A correct run takes well under a tenth of this; a hang ends here.
   initial begin
      #2_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule

// File: sim.f
sv/vrpe_pkg.sv
sv/vrpe_ram.sv
sv/vrpe_ctrl.sv
sv/vrpe_peak.sv
sv/voice_record_playback_engine.sv
sv/vrpe_checker.sv
tb/voice_record_playback_engine_tb.sv
